// ----- rtl/spr_pkg.sv -----
// Shared types and constants for the serial port register block.
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RX_BYTE = 2'd2,
    OP_TX_DONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_BUSY = 2'd2
  } mode_e;

  localparam logic [2:0] REG_CTRL = 3'd0;
  localparam logic [2:0] REG_TX   = 3'd1;
  localparam logic [2:0] REG_RX   = 3'd2;

  typedef struct packed {
    mode_e      tx_mode;
    mode_e      rx_mode;
    logic       tx_en;
    logic       rx_en;
    logic       irq_en;
    logic       tx_full;
    logic       rx_full;
    logic [7:0] tx_hold;
    logic [7:0] rx_hold;
    logic       irq_line;
  } spr_state_t;

  localparam spr_state_t STATE_RESET = '{
    tx_mode:  MODE_OFF,
    rx_mode:  MODE_OFF,
    tx_en:    1'b0,
    rx_en:    1'b0,
    irq_en:   1'b0,
    tx_full:  1'b0,
    rx_full:  1'b0,
    tx_hold:  8'h00,
    rx_hold:  8'h00,
    irq_line: 1'b0
  };

  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_taken;
    logic        irq;
  } spr_result_t;

endpackage

`default_nettype wire

// ----- rtl/spr_core.sv -----
// Next-state and result logic for one beat of the serial port registers.
`timescale 1ns / 1ps
`default_nettype none

module spr_core
  import spr_pkg::*;
(
  input  spr_state_t  state_i,
  input  logic [1:0]  op_i,
  input  logic [2:0]  reg_index_i,
  input  logic [3:0]  byte_mask_i,
  input  logic [31:0] write_data_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        irq_wired_i,
  output spr_state_t  state_o,
  output spr_result_t result_o
);

  // The byte is placed in the highest enabled lane, or nowhere.
  function automatic logic [31:0] place_byte(input logic [3:0] mask, input logic [7:0] b);
    logic [31:0] w;
    w = '0;
    if (mask[3]) w[31:24] = b;
    else if (mask[2]) w[23:16] = b;
    else if (mask[1]) w[15:8] = b;
    else if (mask[0]) w[7:0] = b;
    return w;
  endfunction

  // Byte of the highest enabled lane; the old byte is kept when no lane is enabled.
  function automatic logic [7:0] pick_byte(input logic [3:0] mask, input logic [31:0] w,
                                           input logic [7:0] keep);
    logic [7:0] b;
    b = keep;
    if (mask[3]) b = w[31:24];
    else if (mask[2]) b = w[23:16];
    else if (mask[1]) b = w[15:8];
    else if (mask[0]) b = w[7:0];
    return b;
  endfunction

  always_comb begin
    spr_state_t  s;
    spr_result_t r;
    logic [2:0]  low;
    s   = state_i;
    r   = '0;
    low = byte_mask_i[0] ? write_data_i[2:0] : 3'b000;
    unique case (op_e'(op_i))
      OP_READ: begin
        if (reg_index_i == REG_CTRL) begin
          r.read_data = {27'd0, s.rx_full, s.tx_full, s.irq_en, s.rx_en, s.tx_en};
        end else if (reg_index_i == REG_TX) begin
          r.read_data = {s.tx_hold, 24'd0};
        end else if (reg_index_i == REG_RX) begin
          r.read_data = place_byte(byte_mask_i, s.rx_hold);
          if (state_i.rx_mode == MODE_BUSY) begin
            s.rx_mode  = MODE_ON;
            s.rx_full  = 1'b0;
            s.irq_line = 1'b0;
          end
        end
      end
      OP_WRITE: begin
        if (reg_index_i == REG_CTRL) begin
          s.tx_en  = low[0];
          s.rx_en  = low[1];
          s.irq_en = low[2];
          if (state_i.tx_mode == MODE_OFF && low[0]) begin
            s.tx_mode = MODE_ON;
          end else if (state_i.tx_mode == MODE_ON && !low[0]) begin
            s.tx_mode = MODE_OFF;
            s.tx_full = 1'b0;
          end
          if (state_i.rx_mode == MODE_OFF && low[1]) begin
            s.rx_mode = MODE_ON;
            s.rx_full = 1'b0;
          end else if (state_i.rx_mode == MODE_BUSY && !low[1]) begin
            s.rx_mode  = MODE_OFF;
            s.rx_full  = 1'b0;
            s.rx_hold  = 8'h00;
            s.irq_line = 1'b0;
          end
        end else if (reg_index_i == REG_TX && state_i.tx_mode == MODE_ON) begin
          s.tx_hold  = pick_byte(byte_mask_i, write_data_i, state_i.tx_hold);
          s.tx_full  = 1'b1;
          s.tx_mode  = MODE_BUSY;
          r.tx_valid = 1'b1;
          r.tx_byte  = s.tx_hold;
        end
      end
      OP_RX_BYTE: begin
        if (state_i.rx_mode == MODE_ON) begin
          s.rx_mode  = MODE_BUSY;
          s.rx_full  = 1'b1;
          s.rx_hold  = rx_byte_i;
          r.rx_taken = 1'b1;
          if (state_i.irq_en && irq_wired_i) s.irq_line = 1'b1;
        end
      end
      OP_TX_DONE: begin
        if (state_i.tx_mode == MODE_BUSY) begin
          s.tx_full = 1'b0;
          s.tx_mode = MODE_ON;
        end
      end
      default: begin
      end
    endcase
    r.irq    = s.irq_line & irq_wired_i;
    state_o  = s;
    result_o = r;
  end

endmodule

`default_nettype wire

// ----- rtl/serial_port_registers.sv -----
// Top level of the byte serial port with its control, transmit and receive registers.
// Each beat is one event (bus read, bus write, received byte offered, transmit done) and
// yields one result beat. A beat is captured in an input register and worked out from
// there into the result register, so one beat can be accepted every cycle while the
// output is not stalled; the input register also serves as the skid stage while a
// result waits to be taken. The interrupt_wired register resets to 1 and is written
// through cfg_we_i by the user only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module serial_port_registers
  import spr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [2:0]  reg_index_i,
  input  logic [3:0]  byte_mask_i,
  input  logic [31:0] write_data_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        rx_taken_o,
  output logic        irq_o
);

  logic        irq_wired_q;
  logic        in_full_q;
  logic [1:0]  op_q;
  logic [2:0]  reg_index_q;
  logic [3:0]  byte_mask_q;
  logic [31:0] write_data_q;
  logic [7:0]  rx_byte_q;
  logic        out_full_q;
  spr_result_t result_q;
  spr_result_t result_d;
  spr_state_t  state_q;
  spr_state_t  state_d;
  logic        advance;
  logic        in_take;

  assign advance    = in_full_q && (!out_full_q || !out_stall_i);
  assign in_stall_o = in_full_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_wired_q <= 1'b1;
    end else if (cfg_we_i) begin
      irq_wired_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_take) begin
      in_full_q <= 1'b1;
    end else if (advance) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q         <= op_i;
      reg_index_q  <= reg_index_i;
      byte_mask_q  <= byte_mask_i;
      write_data_q <= write_data_i;
      rx_byte_q    <= rx_byte_i;
    end
  end

  spr_core u_core (
    .state_i      (state_q),
    .op_i         (op_q),
    .reg_index_i  (reg_index_q),
    .byte_mask_i  (byte_mask_q),
    .write_data_i (write_data_q),
    .rx_byte_i    (rx_byte_q),
    .irq_wired_i  (irq_wired_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= STATE_RESET;
      out_full_q <= 1'b0;
    end else if (advance) begin
      state_q    <= state_d;
      out_full_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_full_q;
  assign read_data_o = result_q.read_data;
  assign tx_valid_o  = result_q.tx_valid;
  assign tx_byte_o   = result_q.tx_byte;
  assign rx_taken_o  = result_q.rx_taken;
  assign irq_o       = result_q.irq;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result beat");

  a_tx_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.tx_full == (state_q.tx_mode == MODE_BUSY))
    else $error("transmit full flag disagrees with transmit state");

  a_rx_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.rx_full == (state_q.rx_mode == MODE_BUSY))
    else $error("receive full flag disagrees with receive state");

  a_irq_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.irq_line |-> (state_q.rx_mode == MODE_BUSY))
    else $error("interrupt raised without a held received byte");

  a_tx_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tx_valid_o) |-> (state_q.tx_mode == MODE_BUSY))
    else $error("transmit beat shown while transmitter is not busy");

endmodule

`default_nettype wire
